// File: rtl/core/paac_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// paac_pkg
// Shared constants and types for the polygon area and angle checker.
// ============================================================================
package paac_pkg;

    // Default sizes; the top level hands these down as parameters.
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;

    // Fixed result and register widths.
    localparam int AREA_W   = 42;
    localparam int VCOUNT_W = 11;
    localparam int TARGET_W = 11;
    localparam int RAC_W    = 11;
    localparam int SUM_W    = 64;

    localparam logic [RAC_W-1:0] RAC_MAX = {RAC_W{1'b1}};

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Vertices carried by one job word.
    localparam int NUM_JV = 5;
    localparam int V_P    = 0;   // incoming vertex
    localparam int V_A    = 1;   // most recent vertex used for the geometry before this one
    localparam int V_B    = 2;   // the one before that
    localparam int V_F0   = 3;   // first vertex of the polygon
    localparam int V_F1   = 4;   // second vertex of the polygon

    localparam int AX_X = 0;
    localparam int AX_Y = 1;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_COUNT = '0;

    // Classification of one accepted vertex, made by the front part.
    typedef struct packed {
        logic geom;       // vertex is used for the geometry
        logic do_cross;   // add the cross product with the previous vertex
        logic do_angle;   // test the angle at the previous vertex
        logic last;       // vertex closes the polygon
        logic ovf;        // too many vertices seen, including this one
    } paac_ctl_t;

endpackage

// File: rtl/core/paac_vtx_if.sv
`timescale 1ns / 1ps
// ============================================================================
// paac_vtx_if
// Vertex channel: one word is one polygon vertex.
// ============================================================================
interface paac_vtx_if #(
    parameter int COORD_BITS = paac_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;

    modport source (output valid, output x, output y, output last, input ready);
    modport sink   (input valid, input x, input y, input last, output ready);
endinterface

// File: rtl/core/paac_res_if.sv
`timescale 1ns / 1ps
// ============================================================================
// paac_res_if
// Result channel: one word is the summary of one closed polygon.
// ============================================================================
interface paac_res_if ();
    import paac_pkg::*;

    logic                valid;
    logic                ready;
    logic [AREA_W-1:0]   doubled_area;
    logic [VCOUNT_W-1:0] vertex_count;
    logic                is_rectangle;
    logic                has_right_angle;
    logic                is_even;
    logic                count_matches;
    logic                count_overflow;

    modport source (output valid, output doubled_area, output vertex_count,
                    output is_rectangle, output has_right_angle, output is_even,
                    output count_matches, output count_overflow, input ready);
    modport sink   (input valid, input doubled_area, input vertex_count,
                    input is_rectangle, input has_right_angle, input is_even,
                    input count_matches, input count_overflow, output ready);
endinterface

// File: rtl/core/paac_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// paac_queue
// Small register queue that decouples the front part from the back part.
// ============================================================================
module paac_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    import paac_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [W-1:0]     mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule

// File: rtl/core/paac_front.sv
`timescale 1ns / 1ps
// ============================================================================
// paac_front
// Tracks the vertex history of the open polygon and turns each accepted
// vertex into a self-contained job word for the back part.
// ============================================================================
module paac_front #(
    parameter int MAX_VERTICES = paac_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = paac_pkg::COORD_BITS_DEF,
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                fire,
    input  logic signed [COORD_BITS-1:0]                        x,
    input  logic signed [COORD_BITS-1:0]                        y,
    input  logic                                                last,
    output paac_pkg::paac_ctl_t                                 job_ctl,
    output logic [CNT_W-1:0]                                    job_n,
    output logic [paac_pkg::NUM_JV-1:0][1:0][COORD_BITS-1:0]    job_vtx
);
    import paac_pkg::*;

    typedef logic [1:0][COORD_BITS-1:0] vtx_t;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    vtx_t             r0_reg, r0_next;
    vtx_t             r1_reg, r1_next;
    vtx_t             f0_reg, f0_next;
    vtx_t             f1_reg, f1_next;
    vtx_t             p;
    logic             geom;
    logic [CNT_W-1:0] n_after;

    always_comb
    begin
        p[AX_X] = x;
        p[AX_Y] = y;
    end

    // Vertices past the maximum only mark overflow.
    assign geom    = (cnt_reg < CNT_W'(MAX_VERTICES));
    assign n_after = geom ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        f0_next = (geom && (cnt_reg == '0)) ? p : f0_reg;
        f1_next = (geom && (cnt_reg == CNT_W'(1))) ? p : f1_reg;
        r0_next = geom ? p : r0_reg;
        r1_next = geom ? r0_reg : r1_reg;

        job_ctl.geom     = geom;
        job_ctl.do_cross = geom && (cnt_reg != '0);
        job_ctl.do_angle = geom && (cnt_reg > CNT_W'(1));
        job_ctl.last     = last;
        job_ctl.ovf      = ovf_reg || !geom;

        job_n            = n_after;
        job_vtx[V_P]     = p;
        job_vtx[V_A]     = r0_reg;
        job_vtx[V_B]     = r1_reg;
        job_vtx[V_F0]    = f0_next;
        job_vtx[V_F1]    = f1_next;

        // The closing vertex starts a fresh polygon.
        cnt_next = last ? '0 : n_after;
        ovf_next = last ? 1'b0 : job_ctl.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    // History is only read where the count says it has been written.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            r0_reg <= r0_next;
            r1_reg <= r1_next;
            f0_reg <= f0_next;
            f1_reg <= f1_next;
        end
    end
endmodule

// File: rtl/core/paac_back.sv
`timescale 1ns / 1ps
// ============================================================================
// paac_back
// Job pipeline: products, cross terms and angle tests, the running shoelace
// sum and right-angle count, and the result register.
// ============================================================================
module paac_back #(
    parameter int MAX_VERTICES = paac_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = paac_pkg::COORD_BITS_DEF,
    localparam int CNT_W       = $clog2(MAX_VERTICES + 1)
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                job_valid,
    output logic                                                job_ready,
    input  paac_pkg::paac_ctl_t                                 job_ctl,
    input  logic [CNT_W-1:0]                                    job_n,
    input  logic [paac_pkg::NUM_JV-1:0][1:0][COORD_BITS-1:0]    job_vtx,
    input  logic [paac_pkg::TARGET_W-1:0]                       target_count,
    paac_res_if.source                                          res
);
    import paac_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PW    = 2 * CB;
    localparam int DW    = CB + 1;
    localparam int DPW   = 2 * DW;
    localparam int CMP_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

    typedef logic [1:0][CB-1:0] vtx_t;

    logic move;

    // Stage 1: products
    logic                  s1_valid_reg;
    paac_ctl_t             s1_ctl_reg;
    logic                  s1_close_reg, s1_close_next;
    logic [CNT_W-1:0]      s1_n_reg;
    logic signed [PW-1:0]  cprod_reg [2][2];
    logic signed [PW-1:0]  cprod_next [2][2];
    logic signed [DPW-1:0] dprod_reg [3][2];
    logic signed [DPW-1:0] dprod_next [3][2];
    vtx_t                  va, vb, vp, vf0, vf1, vr0, vr1;
    logic signed [CB-1:0]  tx [3][3];
    logic signed [CB-1:0]  ty [3][3];
    logic signed [DW-1:0]  ux [3];
    logic signed [DW-1:0]  uy [3];
    logic signed [DW-1:0]  wx [3];
    logic signed [DW-1:0]  wy [3];

    // Stage 2: cross terms and angle tests
    logic                   s2_valid_reg;
    logic                   s2_last_reg;
    logic                   s2_ovf_reg;
    logic [CNT_W-1:0]       s2_n_reg;
    logic signed [SUM_W-1:0] s2_delta_reg, s2_delta_next;
    logic [1:0]             s2_inc_reg, s2_inc_next;
    logic signed [SUM_W-1:0] term_reg_part;
    logic signed [SUM_W-1:0] term_close_part;
    logic signed [DPW:0]    dsum [3];
    logic [2:0]             is_right;

    // Stage 3: accumulation
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [RAC_W-1:0]       rac_reg, rac_next;
    logic [SUM_W-1:0]       sum;
    logic [RAC_W:0]         rac_wide;
    logic [RAC_W-1:0]       rac_sat;
    logic                   fin_valid_reg;
    logic [SUM_W-1:0]       fin_sum_reg, fin_sum_next;
    logic [VCOUNT_W-1:0]    fin_cnt_reg;
    logic                   fin_rect_reg, fin_right_reg, fin_even_reg;
    logic                   fin_match_reg, fin_ovf_reg;
    logic                   n_ge3;

    // Output register
    logic                   out_valid_reg;
    logic [AREA_W-1:0]      out_area_reg;
    logic [VCOUNT_W-1:0]    out_cnt_reg;
    logic                   out_rect_reg, out_right_reg, out_even_reg;
    logic                   out_match_reg, out_ovf_reg;
    logic [SUM_W-1:0]       fin_abs;

    // The whole pipeline holds only while a result waits at the output.
    assign move      = !out_valid_reg || res.ready;
    assign job_ready = move;

    // ---------------- stage 1 ----------------
    always_comb
    begin
        vp  = job_vtx[V_P];
        va  = job_vtx[V_A];
        vb  = job_vtx[V_B];
        vf0 = job_vtx[V_F0];
        vf1 = job_vtx[V_F1];
        // Last accepted vertex and the one before it, after this vertex.
        vr0 = job_ctl.geom ? vp : va;
        vr1 = job_ctl.geom ? va : vb;

        s1_close_next = job_ctl.last && (job_n >= CNT_W'(3));

        // Angle at the previous vertex, then the two wrap-around angles.
        tx[0][0] = $signed(vb[AX_X]);  ty[0][0] = $signed(vb[AX_Y]);
        tx[0][1] = $signed(va[AX_X]);  ty[0][1] = $signed(va[AX_Y]);
        tx[0][2] = $signed(vp[AX_X]);  ty[0][2] = $signed(vp[AX_Y]);
        tx[1][0] = $signed(vr1[AX_X]); ty[1][0] = $signed(vr1[AX_Y]);
        tx[1][1] = $signed(vr0[AX_X]); ty[1][1] = $signed(vr0[AX_Y]);
        tx[1][2] = $signed(vf0[AX_X]); ty[1][2] = $signed(vf0[AX_Y]);
        tx[2][0] = $signed(vr0[AX_X]); ty[2][0] = $signed(vr0[AX_Y]);
        tx[2][1] = $signed(vf0[AX_X]); ty[2][1] = $signed(vf0[AX_Y]);
        tx[2][2] = $signed(vf1[AX_X]); ty[2][2] = $signed(vf1[AX_Y]);

        for (int k = 0; k < 3; k++)
        begin
            ux[k] = DW'(tx[k][1]) - DW'(tx[k][0]);
            uy[k] = DW'(ty[k][1]) - DW'(ty[k][0]);
            wx[k] = DW'(tx[k][2]) - DW'(tx[k][1]);
            wy[k] = DW'(ty[k][2]) - DW'(ty[k][1]);
            dprod_next[k][0] = DPW'(ux[k]) * DPW'(wx[k]);
            dprod_next[k][1] = DPW'(uy[k]) * DPW'(wy[k]);
        end

        cprod_next[0][0] = PW'($signed(va[AX_X])) * PW'($signed(vp[AX_Y]));
        cprod_next[0][1] = PW'($signed(vp[AX_X])) * PW'($signed(va[AX_Y]));
        cprod_next[1][0] = PW'($signed(vr0[AX_X])) * PW'($signed(vf0[AX_Y]));
        cprod_next[1][1] = PW'($signed(vf0[AX_X])) * PW'($signed(vr0[AX_Y]));
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        term_reg_part   = SUM_W'(cprod_reg[0][0]) - SUM_W'(cprod_reg[0][1]);
        term_close_part = SUM_W'(cprod_reg[1][0]) - SUM_W'(cprod_reg[1][1]);
        s2_delta_next   = (s1_ctl_reg.do_cross ? term_reg_part : '0)
                        + (s1_close_reg ? term_close_part : '0);

        for (int k = 0; k < 3; k++)
        begin
            dsum[k]     = (DPW + 1)'(dprod_reg[k][0]) + (DPW + 1)'(dprod_reg[k][1]);
            is_right[k] = (dsum[k] == '0);
        end

        s2_inc_next = 2'(s1_ctl_reg.do_angle && is_right[0])
                    + 2'(s1_close_reg && is_right[1])
                    + 2'(s1_close_reg && is_right[2]);
    end

    // ---------------- stage 3 ----------------
    always_comb
    begin
        sum      = acc_reg + s2_delta_reg;
        rac_wide = {1'b0, rac_reg} + (RAC_W + 1)'(s2_inc_reg);
        rac_sat  = (rac_wide > (RAC_W + 1)'(RAC_MAX)) ? RAC_MAX : rac_wide[RAC_W-1:0];
        n_ge3    = (s2_n_reg >= CNT_W'(3));

        // Below three vertices the area is defined as zero.
        fin_sum_next = n_ge3 ? sum : '0;

        if (s2_last_reg)
        begin
            acc_next = '0;
            rac_next = '0;
        end
        else
        begin
            acc_next = sum;
            rac_next = rac_sat;
        end

        fin_abs = fin_sum_reg[SUM_W-1] ? (~fin_sum_reg + 1'b1) : fin_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            rac_reg       <= '0;
        end
        else if (move)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            fin_valid_reg <= s2_valid_reg && s2_last_reg;
            out_valid_reg <= fin_valid_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
                rac_reg <= rac_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            s1_ctl_reg   <= job_ctl;
            s1_close_reg <= s1_close_next;
            s1_n_reg     <= job_n;
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    cprod_reg[i][j] <= cprod_next[i][j];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    dprod_reg[k][j] <= dprod_next[k][j];
                end
            end

            s2_last_reg  <= s1_ctl_reg.last;
            s2_ovf_reg   <= s1_ctl_reg.ovf;
            s2_n_reg     <= s1_n_reg;
            s2_delta_reg <= s2_delta_next;
            s2_inc_reg   <= s2_inc_next;

            fin_sum_reg   <= fin_sum_next;
            fin_cnt_reg   <= VCOUNT_W'(s2_n_reg);
            fin_rect_reg  <= (s2_n_reg == CNT_W'(4)) && (rac_sat == RAC_W'(4));
            fin_right_reg <= n_ge3 && (rac_sat != '0);
            fin_even_reg  <= !s2_n_reg[0];
            fin_match_reg <= (CMP_W'(s2_n_reg) == CMP_W'(target_count));
            fin_ovf_reg   <= s2_ovf_reg;

            out_area_reg  <= fin_abs[AREA_W-1:0];
            out_cnt_reg   <= fin_cnt_reg;
            out_rect_reg  <= fin_rect_reg;
            out_right_reg <= fin_right_reg;
            out_even_reg  <= fin_even_reg;
            out_match_reg <= fin_match_reg;
            out_ovf_reg   <= fin_ovf_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.doubled_area    = out_area_reg;
    assign res.vertex_count    = out_cnt_reg;
    assign res.is_rectangle    = out_rect_reg;
    assign res.has_right_angle = out_right_reg;
    assign res.is_even         = out_even_reg;
    assign res.count_matches   = out_match_reg;
    assign res.count_overflow  = out_ovf_reg;
endmodule

// File: rtl/core/polygon_area_and_angle_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// polygon_area_and_angle_checker
// Streaming shoelace area and right-angle checker for integer polygons.
// ============================================================================
//
//   Channel   Dir   Word                              Handshake
//   -------   ---   --------------------------------  ----------------------
//   vtx       in    x, y, last                        valid / ready
//   res       out   doubled_area, vertex_count, flags valid / ready
//   apb       in    target_count register at byte 0   psel / penable, pready=1
//
// One vertex word is accepted every clock cycle while the queue has room; the
// rate is set by the back pipeline, which takes one job per cycle from the queue
// unless a result stalls. After the closing vertex of a polygon is accepted, its
// queue entry is written at the accepting edge, and the job then passes through
// the product stage, the term stage, the sum stage and the result register in
// turn before its summary is valid at the output.
// Reset (rst_n low, asynchronous) empties the queue and the pipeline and
// clears the open polygon and target_count; no clearing pass is needed.
// A stalled result holds the whole back pipeline; the four-word queue keeps
// taking vertices until it fills, and then vtx.ready drops.
//
module polygon_area_and_angle_checker #(
    parameter int MAX_VERTICES = paac_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = paac_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [paac_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [paac_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [paac_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    paac_vtx_if.sink                            vtx,
    paac_res_if.source                          res
);
    import paac_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int VTX_W = NUM_JV * 2 * COORD_BITS;
    localparam int JOB_W = $bits(paac_ctl_t) + CNT_W + VTX_W;

    // Configuration register. The user must write it only while the block is idle; the block does not enforce this.
    logic [TARGET_W-1:0] target_count_reg;
    logic                reg_hit;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_TARGET_COUNT);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? APB_DATA_W'(target_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= '0;
        end
        else if (cfg_write && reg_hit)
        begin
            target_count_reg <= pwdata[TARGET_W-1:0];
        end
    end

    // Front part: classifies each vertex against the polygon history and
    // builds a job word that carries every operand the back part needs.
    paac_ctl_t                                 f_ctl;
    logic [CNT_W-1:0]                          f_n;
    logic [NUM_JV-1:0][1:0][COORD_BITS-1:0]    f_vtx;
    logic                                      q_in_ready;
    logic                                      fire;

    assign vtx.ready = q_in_ready;
    assign fire      = vtx.valid && q_in_ready;

    paac_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .x       (vtx.x),
        .y       (vtx.y),
        .last    (vtx.last),
        .job_ctl (f_ctl),
        .job_n   (f_n),
        .job_vtx (f_vtx)
    );

    // Job queue between the two parts.
    logic [JOB_W-1:0]                          q_din;
    logic [JOB_W-1:0]                          q_dout;
    logic                                      q_valid;
    logic                                      q_ready;
    paac_ctl_t                                 b_ctl;
    logic [CNT_W-1:0]                          b_n;
    logic [NUM_JV-1:0][1:0][COORD_BITS-1:0]    b_vtx;

    assign q_din                = {f_ctl, f_n, f_vtx};
    assign {b_ctl, b_n, b_vtx}  = q_dout;

    paac_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vtx.valid),
        .in_ready  (q_in_ready),
        .in_data   (q_din),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_dout)
    );

    // Back part: products, shoelace accumulation, angle count and the
    // result register that feeds the res channel.
    paac_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_valid),
        .job_ready    (q_ready),
        .job_ctl      (b_ctl),
        .job_n        (b_n),
        .job_vtx      (b_vtx),
        .target_count (target_count_reg),
        .res          (res)
    );

    // A rectangle always has a right angle and exactly four vertices.
    a_rect_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.is_rectangle |->
            res.has_right_angle && (res.vertex_count == VCOUNT_W'(4)))
        else $error("rectangle flag without four vertices and a right angle");

    // Overflow means the vertex count stopped at the maximum.
    a_ovf_count: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.count_overflow |->
            (res.vertex_count == VCOUNT_W'(MAX_VERTICES)))
        else $error("overflow flag with a vertex count below the maximum");

    // A vertex is never taken while the job queue is full.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> q_in_ready && vtx.ready)
        else $error("vertex accepted into a full job queue");
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the polygon area and angle checker. Polygons stream
// in as vertex words, and a shoelace and right-angle predictor inside a small
// scoreboard works out each polygon summary as the closing vertex goes in.
// Each summary word that comes out is compared field by field with the
// prediction. Random idling runs on both channels. The target_count register
// is rewritten between phases while the block is idle.
// ============================================================================
module tb_top;
    import paac_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } vertex_t;

    typedef struct {
        logic [AREA_W-1:0]   doubled_area;
        logic [VCOUNT_W-1:0] vertex_count;
        logic                is_rectangle;
        logic                has_right_angle;
        logic                is_even;
        logic                count_matches;
        logic                count_overflow;
    } summary_t;

    // The scoreboard follows the open polygon one accepted vertex at a time and
    // keeps a queue of the summaries that the block still owes.
    class summary_board;
        summary_t            due[$];
        int                  errors;
        logic [TARGET_W-1:0] target;
        longint              fx[2];
        longint              fy[2];
        longint              ax;        // most recent accepted vertex
        longint              ay;
        longint              bx;        // the accepted vertex before that
        longint              by;
        int                  accepted;
        logic [SUM_W-1:0]    shoelace;
        int                  rights;
        bit                  dropped;

        function new();
            errors = 0;
            target = '0;
            restart_polygon();
        endfunction

        function void restart_polygon();
            fx[0] = 0;
            fy[0] = 0;
            fx[1] = 0;
            fy[1] = 0;
            ax = 0;
            ay = 0;
            bx = 0;
            by = 0;
            accepted = 0;
            shoelace = '0;
            rights = 0;
            dropped = 1'b0;
        endfunction

        function logic [SUM_W-1:0] cross_term(longint px, longint py, longint qx,
                                              longint qy);
            return SUM_W'(px * qy - qx * py);
        endfunction

        // Counts the corner at q when edge p->q is perpendicular to edge q->r.
        // An edge of zero length counts as well.
        function void tally_angle(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
            longint d;
            d = (qx - px) * (rx - qx) + (qy - py) * (ry - qy);
            if (d == 0 && rights < int'(RAC_MAX))
                rights++;
        endfunction

        function void take_vertex(vertex_t v, bit last);
            longint           vx;
            longint           vy;
            summary_t         s;
            logic [SUM_W-1:0] total;
            logic [SUM_W-1:0] mag;
            vx = v.x;
            vy = v.y;
            if (accepted < MAX_VERTICES_DEF)
            begin
                if (accepted >= 1)
                    shoelace += cross_term(ax, ay, vx, vy);
                if (accepted >= 2)
                    tally_angle(bx, by, ax, ay, vx, vy);
                if (accepted < 2)
                begin
                    fx[accepted] = vx;
                    fy[accepted] = vy;
                end
                bx = ax;
                by = ay;
                ax = vx;
                ay = vy;
                accepted++;
            end
            else
                dropped = 1'b1;
            if (!last)
                return;
            s.doubled_area = '0;
            if (accepted >= 3)
            begin
                // Closing edge plus the two corners that wrap around the start.
                total = shoelace + cross_term(ax, ay, fx[0], fy[0]);
                tally_angle(bx, by, ax, ay, fx[0], fy[0]);
                tally_angle(ax, ay, fx[0], fy[0], fx[1], fy[1]);
                mag = total[SUM_W-1] ? -total : total;
                s.doubled_area = mag[AREA_W-1:0];
            end
            s.vertex_count    = VCOUNT_W'(accepted);
            s.is_rectangle    = accepted == 4 && rights == 4;
            s.has_right_angle = accepted >= 3 && rights > 0;
            s.is_even         = accepted % 2 == 0;
            s.count_matches   = accepted == int'(target);
            s.count_overflow  = dropped;
            due.push_back(s);
            restart_polygon();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_summary(summary_t got);
            summary_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: summary word with none expected, area %0d count %0d",
                         $time, got.doubled_area, got.vertex_count);
                return;
            end
            want = due.pop_front();
            compare_field("doubled_area", want.doubled_area, got.doubled_area);
            compare_field("vertex_count", want.vertex_count, got.vertex_count);
            compare_field("is_rectangle", want.is_rectangle, got.is_rectangle);
            compare_field("has_right_angle", want.has_right_angle, got.has_right_angle);
            compare_field("is_even", want.is_even, got.is_even);
            compare_field("count_matches", want.count_matches, got.count_matches);
            compare_field("count_overflow", want.count_overflow, got.count_overflow);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    paac_vtx_if #(.COORD_BITS(CW)) vtx ();
    paac_res_if res ();

    polygon_area_and_angle_checker DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .vtx     (vtx),
        .res     (res)
    );

    always #4 clk = ~clk;

    summary_board board = new();
    int           cycles = 0;
    bit           calm = 1'b0;      // set for the last part of the run: no idling
    int           hold_request = 0; // long receiver hold-off, counted below
    int           hold_left = 0;
    int           stall_left = 0;
    int           sent_in_phase;
    vertex_t      poly[$];          // polygon being built before it is sent

    // Watchdog: a run that never drains ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Every summary word taken at a rising edge goes straight to the scoreboard.
    always @(posedge clk)
    begin
        summary_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got.doubled_area    = res.doubled_area;
            got.vertex_count    = res.vertex_count;
            got.is_rectangle    = res.is_rectangle;
            got.has_right_angle = res.has_right_angle;
            got.is_even         = res.is_even;
            got.count_matches   = res.count_matches;
            got.count_overflow  = res.count_overflow;
            board.check_summary(got);
        end
    end

    // Receiver side. Short stalls come in random bursts unless the run is in its
    // calm part. A long hold-off, when requested, is counted here in cycles
    // while the sender keeps offering vertices, so the four-word queue fills
    // and vtx.ready has to drop.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= 1'b1;
    end

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic void add_vertex(int px, int py);
        vertex_t v;
        v.x = CW'(px);
        v.y = CW'(py);
        poly.push_back(v);
    endfunction

    // A span of zero means the full coordinate range, so every bit of x and y
    // gets exercised; a small span crowds vertices together and makes right
    // angles and repeated vertices common.
    function automatic void build_random(int n, int span);
        for (int i = 0; i < n; i++)
        begin
            if (span == 0)
                add_vertex(int'($urandom), int'($urandom));
            else
                add_vertex(pick(-span, span), pick(-span, span));
        end
    endfunction

    function automatic void build_extreme(int n);
        int corner[5];
        corner = '{-32768, 32767, 0, -1, 1};
        for (int i = 0; i < n; i++)
            add_vertex(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)]);
    endfunction

    // Rectangle from an origin, an edge vector u and the perpendicular k*u.
    // It is either axis aligned or tilted, entered from a random corner in
    // either direction, and now and then knocked out of square by one unit.
    function automatic void build_rectangle(bit perturb);
        int cx[4];
        int cy[4];
        int ox;
        int oy;
        int ux;
        int uy;
        int k;
        int start;
        bit reverse;
        int j;
        ox = pick(-30000, 30000);
        oy = pick(-30000, 30000);
        ux = pick(-200, 200);
        uy = $urandom_range(0, 1) ? 0 : pick(-200, 200);
        k = pick(1, 3);
        cx[0] = ox;
        cy[0] = oy;
        cx[1] = ox + ux;
        cy[1] = oy + uy;
        cx[2] = cx[1] - k * uy;
        cy[2] = cy[1] + k * ux;
        cx[3] = ox - k * uy;
        cy[3] = oy + k * ux;
        if (perturb)
            cx[$urandom_range(0, 3)] += 1;
        start = $urandom_range(0, 3);
        reverse = $urandom_range(0, 1);
        for (int i = 0; i < 4; i++)
        begin
            j = reverse ? (start - i + 4) % 4 : (start + i) % 4;
            add_vertex(cx[j], cy[j]);
        end
    endfunction

    // Offers one vertex word, with a random gap in front of it unless calm.
    // Called and returns at a falling edge; valid is left high so back-to-back
    // words go through one per cycle while vtx.ready stays high.
    task automatic offer_vertex(vertex_t v, bit last);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            vtx.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        vtx.valid <= 1'b1;
        vtx.x     <= v.x;
        vtx.y     <= v.y;
        vtx.last  <= last;
        do
            @(posedge clk);
        while (!vtx.ready);
        board.take_vertex(v, last);
        @(negedge clk);
    endtask

    task automatic send_poly();
        foreach (poly[i])
            offer_vertex(poly[i], i == poly.size() - 1);
        sent_in_phase += poly.size();
        poly.delete();
    endtask

    // Sender stops until every owed summary is back, then lets the pipeline run dry.
    task automatic drain();
        vtx.valid <= 1'b0;
        while (board.due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_access(bit wr, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_TARGET_COUNT, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_target(int unsigned value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(value))
        begin
            board.errors++;
            $display("%0t: target_count readback mismatch, expected %0d, actual %0d",
                     $time, value, rd);
        end
    endtask

    task automatic set_target(int unsigned value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, APB_DATA_W'(value), rd);
        board.target = TARGET_W'(value);
        check_target(value);
    endtask

    // Mostly well-formed polygons with random content; one- and two-vertex
    // polygons stand in for the broken ones.
    task automatic random_polygons(int budget);
        int kind;
        sent_in_phase = 0;
        while (sent_in_phase < budget)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
                build_random(pick(3, 8), 0);
            else if (kind < 50)
                build_random(pick(3, 8), 4);
            else if (kind < 70)
                build_rectangle($urandom_range(0, 3) == 0);
            else if (kind < 80)
                build_extreme(pick(3, 6));
            else if (kind < 90)
                build_random(pick(1, 2), 0);
            else
                build_random(pick(5, 40), $urandom_range(0, 1) ? 0 : 2);
            send_poly();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        vtx.valid = 1'b0;
        vtx.x     = '0;
        vtx.y     = '0;
        vtx.last  = 1'b0;
        res.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The register must come out of reset at zero.
        check_target(0);
        set_target(4);

        // Directed polygons. A lone vertex and a pair give zero area and no
        // right angle.
        add_vertex(32767, -32768);
        send_poly();
        add_vertex(0, 0);
        add_vertex(-32768, 32767);
        send_poly();
        // Square on the coordinate extremes: the largest area, and a rectangle.
        add_vertex(-32768, -32768);
        add_vertex(32767, -32768);
        add_vertex(32767, 32767);
        add_vertex(-32768, 32767);
        send_poly();
        // Sender waits here until every summary owed so far is back.
        drain();
        // Right angle at the first vertex, found only when the polygon wraps.
        add_vertex(0, 0);
        add_vertex(4, 0);
        add_vertex(0, 3);
        send_poly();
        // Counter-clockwise triangle, right angle at the closing vertex.
        add_vertex(4, 0);
        add_vertex(0, 3);
        add_vertex(0, 0);
        send_poly();
        // A repeated vertex makes a zero-length edge, which counts as square.
        add_vertex(1, 1);
        add_vertex(1, 1);
        add_vertex(5, -2);
        send_poly();
        // Tilted rectangle.
        add_vertex(0, 0);
        add_vertex(2, 1);
        add_vertex(1, 3);
        add_vertex(-1, 2);
        send_poly();
        // Plain pentagon with no right angle.
        add_vertex(-7, 3);
        add_vertex(12, -9);
        add_vertex(20, 15);
        add_vertex(0, 25);
        add_vertex(-30000, 100);
        send_poly();
        drain();

        set_target(0);
        random_polygons(190);
        drain();

        // Long receiver hold-off at the start of this phase so the block
        // backs up into the vertex channel.
        set_target(3);
        hold_request = 60;
        random_polygons(190);
        drain();

        // Last part of the run: no idling on either side.
        set_target(pick(5, 12));
        calm = 1'b1;
        random_polygons(190);
        vtx.valid <= 1'b0;
        while (board.due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (board.errors == 0 && board.due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
